### hw/rtl/b2d_pkg.sv
// Package for the signed binary to decimal ASCII converter.
// Shared constants and the cell control struct; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b2d_pkg;

  localparam int unsigned MagWidth  = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BitCntW   = $clog2(MagWidth);
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);

  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'd45;
  localparam logic [3:0] BcdFix     = 4'd3;
  localparam logic [3:0] BcdLimit   = 4'd5;

  typedef struct packed {
    logic clr;
    logic shift;
    logic move;
  } b2d_cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/b2d_cell.sv
// One BCD digit cell of the shift-and-add-3 chain.
// Depends on b2d_pkg for the control struct and correction constants.
`timescale 1ns / 1ps
`default_nettype none

module b2d_cell
  import b2d_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire b2d_cell_ctrl_t ctrl_i,
  input  wire logic           bit_i,
  input  wire logic [3:0]     digit_i,
  output logic                bit_o,
  output logic [3:0]          digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] fixed;

  assign fixed = (digit_q >= BcdLimit) ? digit_q + BcdFix : digit_q;
  assign bit_o = fixed[3];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clr) begin
      digit_d = 4'd0;
    end else if (ctrl_i.shift) begin
      digit_d = {fixed[2:0], bit_i};
    end else if (ctrl_i.move) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/signed_binary_to_decimal_ascii_core.sv
// Top level: signed 32-bit integer to decimal ASCII text, MSD first.
// Depends on b2d_pkg and b2d_cell.
`timescale 1ns / 1ps
`default_nettype none

// A transaction is accepted when start_i is high and busy_o is low. The
// magnitude is shifted through a row of ten BCD digit cells, one bit per
// cycle, then the digit row moves up one cell per cycle and the top cell
// supplies each digit character. Characters appear on char_code_o for one
// cycle each with char_valid_o high; the receiver cannot stall them and must
// take every strobe. last_char_o marks the final character. busy_o drops
// in the cycle that presents the last character.
module signed_binary_to_decimal_ascii_core
  import b2d_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] value_i,
  output logic                    busy_o,
  output logic                    char_valid_o,
  output logic [7:0]              char_code_o,
  output logic                    last_char_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSign = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [MagWidth-1:0]   mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [BitCntW-1:0]    bcnt_q, bcnt_d;
  logic [DigCntW-1:0]    rem_q, rem_d;
  logic                  started_q, started_d;
  logic                  valid_q, valid_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;
  b2d_cell_ctrl_t        ctrl;
  logic                  accept;
  logic [MagWidth-1:0]   raw;
  logic [3:0]            top_digit;
  logic                  is_last;

  logic [3:0]            dig_chain [NumDigits+1];
  logic                  bit_chain [NumDigits+1];

  assign dig_chain[0] = 4'd0;
  assign bit_chain[0] = mag_q[MagWidth-1];

  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    b2d_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bit_i   (bit_chain[i]),
      .digit_i (dig_chain[i]),
      .bit_o   (bit_chain[i+1]),
      .digit_o (dig_chain[i+1])
    );
  end

  assign top_digit = dig_chain[NumDigits];
  assign busy_o    = (state_q != StIdle);
  assign accept    = start_i && !busy_o;
  assign raw       = $unsigned(value_i);
  assign is_last   = (rem_q == DigCntW'(1));

  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    bcnt_d    = bcnt_q;
    rem_d     = rem_q;
    started_d = started_q;
    valid_d   = 1'b0;
    char_d    = char_q;
    last_d    = 1'b0;
    ctrl      = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          neg_d     = raw[MagWidth-1];
          mag_d     = raw[MagWidth-1] ? (MagWidth'(0) - raw) : raw;
          bcnt_d    = '0;
          rem_d     = DigCntW'(NumDigits);
          started_d = 1'b0;
          ctrl.clr  = 1'b1;
          state_d   = StConv;
        end
      end
      StConv: begin
        ctrl.shift = 1'b1;
        mag_d      = {mag_q[MagWidth-2:0], 1'b0};
        bcnt_d     = bcnt_q + BitCntW'(1);
        if (bcnt_q == BitCntW'(MagWidth - 1)) begin
          state_d = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        valid_d = 1'b1;
        char_d  = AsciiMinus;
        state_d = StEmit;
      end
      StEmit: begin
        ctrl.move = 1'b1;
        rem_d     = rem_q - DigCntW'(1);
        if (top_digit != 4'd0 || started_q || is_last) begin
          valid_d   = 1'b1;
          char_d    = AsciiZero + {4'd0, top_digit};
          last_d    = is_last;
          started_d = 1'b1;
        end
        if (is_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bcnt_q    <= '0;
      rem_q     <= '0;
      started_q <= 1'b0;
      valid_q   <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      bcnt_q    <= bcnt_d;
      rem_q     <= rem_d;
      started_q <= started_d;
      valid_q   <= valid_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    char_q <= char_d;
  end

  assign char_valid_o = valid_q;
  assign char_code_o  = char_q;
  assign last_char_o  = last_q;

endmodule

`default_nettype wire

### bench/signed_binary_to_decimal_ascii_core_test.sv
// Testbench for signed_binary_to_decimal_ascii_core: feeds signed integers and
// checks each emitted ASCII character and its last-character flag in order.
// Depends on b2d_pkg and the core RTL.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_core_test
  import b2d_pkg::*;
;

  localparam int unsigned Radix      = 10;
  localparam int          ResetCyc   = 12;
  localparam int          StallLimit = 2000;
  localparam int          TailCyc    = 60;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } ascii_char_t;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start_i = 1'b0;
  logic signed [31:0] value_i = '0;
  logic               busy_o;
  logic               char_valid_o;
  logic [7:0]         char_code_o;
  logic               last_char_o;

  logic signed [31:0] value_queue[$];
  ascii_char_t        text_expected[$];
  int                 error_count   = 0;
  int                 accepted_cnt  = 0;
  int                 burst_left    = 1;
  int                 gap_left      = 0;
  int                 idle_cycles   = 0;
  bit                 drain_hold    = 1'b0;

  signed_binary_to_decimal_ascii_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .char_valid_o(char_valid_o),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  always #5 clk_i = ~clk_i;

  // Decimal text of v, sign first, most significant digit first.
  function automatic void predict_text(logic signed [31:0] v);
    logic [31:0] mag;
    logic [7:0]  digits[$];
    ascii_char_t ch;
    mag = v[31] ? (32'd0 - v) : v;
    do begin
      digits.push_front(AsciiZero + 8'(mag % Radix));
      mag = mag / Radix;
    end while (mag != 0);
    if (v[31]) begin
      ch.code = AsciiMinus;
      ch.last = 1'b0;
      text_expected.push_back(ch);
    end
    foreach (digits[i]) begin
      ch.code = digits[i];
      ch.last = (i == digits.size() - 1);
      text_expected.push_back(ch);
    end
  endfunction

  // Driver: bursts of transactions with random gaps, occasional full drain.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      value_i <= '0;
    end else begin
      if (start_i && !busy_o) begin
        predict_text(value_i);
        accepted_cnt++;
        if (accepted_cnt % 150 == 25) drain_hold = 1'b1;
      end
      if (!start_i || !busy_o) begin
        if (drain_hold && text_expected.size() != 0) begin
          start_i <= 1'b0;
          value_i <= $urandom();
        end else begin
          drain_hold = 1'b0;
          if (gap_left > 0) begin
            gap_left--;
            start_i <= 1'b0;
            value_i <= $urandom();
          end else if (value_queue.size() != 0) begin
            start_i <= 1'b1;
            value_i <= value_queue.pop_front();
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(12, 1);
              gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 1);
            end
          end else begin
            start_i <= 1'b0;
          end
        end
      end
    end
  end

  // Monitor: every strobe is a character transaction.
  always @(posedge clk_i) begin
    ascii_char_t exp_ch;
    if (rst_ni && char_valid_o) begin
      if (text_expected.size() == 0) begin
        $error("unexpected char_code %0d last_char %0d", char_code_o, last_char_o);
        error_count++;
      end else begin
        exp_ch = text_expected.pop_front();
        if (char_code_o !== exp_ch.code) begin
          $error("char_code expected %0d actual %0d", exp_ch.code, char_code_o);
          error_count++;
        end
        if (last_char_o !== exp_ch.last) begin
          $error("last_char expected %0d actual %0d", exp_ch.last, last_char_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || char_valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    longint             lo;
    longint             hi;
    int unsigned        mag;
    int                 ndig;
    logic signed [31:0] v;

    value_queue.push_back(32'sd0);
    value_queue.push_back(32'sd1);
    value_queue.push_back(-32'sd1);
    value_queue.push_back(32'sd7);
    value_queue.push_back(-32'sd9);
    value_queue.push_back(32'sd9);
    value_queue.push_back(32'sd10);
    value_queue.push_back(-32'sd10);
    value_queue.push_back(32'sd99);
    value_queue.push_back(32'sd100);
    value_queue.push_back(-32'sd100000);
    value_queue.push_back(32'sd999999999);
    value_queue.push_back(32'sd1000000000);
    value_queue.push_back(-32'sd1000000000);
    value_queue.push_back(32'sd1234567890);
    value_queue.push_back(-32'sd1234567890);
    value_queue.push_back(32'sd2000000000);
    value_queue.push_back(32'sh7FFF_FFFF);
    value_queue.push_back(32'sh8000_0000);
    value_queue.push_back(32'sh8000_0001);
    value_queue.push_back(32'sh5555_5555);
    value_queue.push_back(32'shAAAA_AAAA);
    value_queue.push_back(32'sd1000);

    repeat (450) begin
      if ($urandom_range(9, 0) < 3) begin
        v = $urandom();
      end else begin
        ndig = $urandom_range(10, 1);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        mag = $urandom_range(hi[31:0], lo[31:0]);
        v = mag;
        if ($urandom_range(1, 0) == 1) v = -v;
      end
      value_queue.push_back(v);
    end

    repeat (ResetCyc) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (value_queue.size() != 0 || start_i || text_expected.size() != 0);
    repeat (TailCyc) @(posedge clk_i);

    if (error_count == 0 && text_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (text_expected.size() != 0) $error("%0d characters never arrived", text_expected.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/b2d_pkg.sv
hw/rtl/b2d_cell.sv
hw/rtl/signed_binary_to_decimal_ascii_core.sv
bench/signed_binary_to_decimal_ascii_core_test.sv
